/* design/sppq_pkg.sv */
// shared types and constants for the sorted priority process queue
// no dependencies
`default_nettype none

package sppq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int ID_W     = 16;
   localparam int PRIO_W   = 16;
   localparam int OP_W     = 2;
   localparam int STAT_W   = 2;
   localparam int OCC_W    = 5;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic fin_ready;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

/* design/sppq_ram.sv */
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module sppq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/sppq_ctrl.sv */
// controller state machine: accepts a word, steps the walk, issues finish
// depends on sppq_pkg
`default_nettype none

module sppq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire sppq_pkg::sts_type sts,
   output sppq_pkg::cmd_type      cmd
);

   import sppq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.fin_ready) begin
               if (sts.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/sppq_dpath.sv */
// datapath: entry ram, walk counters, held count and result register
// depends on sppq_pkg and sppq_ram
`default_nettype none

module sppq_dpath #(
   parameter int QUEUE_DEPTH = sppq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sppq_pkg::cmd_type            cmd,
   output sppq_pkg::sts_type                 sts,
   input  wire logic [sppq_pkg::OP_W-1:0]    req_op,
   input  wire logic [sppq_pkg::ID_W-1:0]    req_id,
   input  wire logic [sppq_pkg::PRIO_W-1:0]  req_prio,
   output logic                              rsp_valid,
   input  wire logic                         rsp_tready,
   output logic [sppq_pkg::STAT_W-1:0]       rsp_status,
   output logic [sppq_pkg::ID_W-1:0]         rsp_id,
   output logic [sppq_pkg::PRIO_W-1:0]       rsp_prio,
   output logic [sppq_pkg::OCC_W-1:0]        rsp_occ
);

   import sppq_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   // control registers
   logic [CW-1:0] count_ff,   count_in;
   logic          pend_ff,    pend_in;
   logic          found_ff,   found_in;
   logic          rsp_vld_ff, rsp_vld_in;

   // payload registers
   logic [OP_W-1:0]   op_ff,        op_in;
   logic [ID_W-1:0]   id_ff,        id_in;
   logic [PRIO_W-1:0] prio_ff,      prio_in;
   logic [IW-1:0]     rd_idx_ff,    rd_idx_in;
   logic [CW-1:0]     rd_left_ff,   rd_left_in;
   logic [IW-1:0]     pend_idx_ff,  pend_idx_in;
   logic [ID_W-1:0]   hit_id_ff,    hit_id_in;
   logic [PRIO_W-1:0] hit_prio_ff,  hit_prio_in;
   logic [STAT_W-1:0] rsp_stat_ff,  rsp_stat_in;
   logic [ID_W-1:0]   rsp_id_ff,    rsp_id_in;
   logic [PRIO_W-1:0] rsp_prio_ff,  rsp_prio_in;
   logic [OCC_W-1:0]  rsp_occ_ff,   rsp_occ_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;
   logic          rd_en;
   entry_type     rd_data;
   logic          is_ins;
   logic          full;
   logic          ins_stop;
   logic          walk_end;
   logic [CW-1:0] count_nx;

   sppq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign is_ins   = (op_ff == OP_INSERT);
   assign full     = (count_ff == FULL_CNT);
   assign ins_stop = pend_ff && is_ins && (rd_data.prio <= prio_ff);
   assign walk_end = !pend_ff && (rd_left_ff == '0);

   assign sts.fin_ready = ins_stop || walk_end;
   assign sts.out_free  = !rsp_vld_ff || rsp_tready;

   always_comb begin
      count_in    = count_ff;
      pend_in     = pend_ff;
      found_in    = found_ff;
      rsp_vld_in  = rsp_vld_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      prio_in     = prio_ff;
      rd_idx_in   = rd_idx_ff;
      rd_left_in  = rd_left_ff;
      pend_idx_in = pend_idx_ff;
      hit_id_in   = hit_id_ff;
      hit_prio_in = hit_prio_ff;
      rsp_stat_in = rsp_stat_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_prio_in = rsp_prio_ff;
      rsp_occ_in  = rsp_occ_ff;
      count_nx    = count_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = rd_data;
      rd_en       = 1'b0;

      if (cmd.load) begin
         op_in       = req_op;
         id_in       = req_id;
         prio_in     = req_prio;
         found_in    = 1'b0;
         pend_in     = 1'b0;
         hit_id_in   = '0;
         hit_prio_in = '0;
         case (req_op) inside
            OP_INSERT: begin
               // walk from the tail toward the head
               rd_left_in = full ? '0 : count_ff;
               rd_idx_in  = IW'(count_ff - 1'b1);
            end
            OP_DELETE, OP_DEQUEUE: begin
               rd_left_in = count_ff;
               rd_idx_in  = '0;
            end
            default: begin
               rd_left_in = '0;
               rd_idx_in  = '0;
            end
         endcase
      end

      if (cmd.step) begin
         if (rd_left_ff != '0) begin
            rd_en       = 1'b1;
            pend_in     = 1'b1;
            pend_idx_in = rd_idx_ff;
            rd_left_in  = rd_left_ff - 1'b1;
            rd_idx_in   = is_ins ? IW'(rd_idx_ff - 1'b1) : IW'(rd_idx_ff + 1'b1);
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff) begin
            if (is_ins) begin
               // larger priority moves one slot toward the tail
               wr_en   = 1'b1;
               wr_addr = IW'(pend_idx_ff + 1'b1);
            end else if (found_ff) begin
               // close the gap behind the removed entry
               wr_en   = 1'b1;
               wr_addr = IW'(pend_idx_ff - 1'b1);
            end else if ((op_ff == OP_DEQUEUE) || (rd_data.id == id_ff)) begin
               found_in    = 1'b1;
               hit_id_in   = rd_data.id;
               hit_prio_in = rd_data.prio;
            end
         end
      end

      if (cmd.finish) begin
         pend_in     = 1'b0;
         rsp_vld_in  = 1'b1;
         rsp_id_in   = hit_id_ff;
         rsp_prio_in = hit_prio_ff;
         rsp_stat_in = ST_OK;
         case (op_ff)
            OP_INSERT: begin
               if (full) begin
                  rsp_stat_in = ST_FULL;
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = pend_ff ? IW'(pend_idx_ff + 1'b1) : '0;
                  wr_data.id   = id_ff;
                  wr_data.prio = prio_ff;
                  count_nx     = count_ff + 1'b1;
               end
            end
            OP_DELETE: begin
               if (found_ff) begin
                  count_nx = count_ff - 1'b1;
               end else begin
                  rsp_stat_in = ST_NOT_FOUND;
               end
            end
            OP_DEQUEUE: begin
               if (found_ff) begin
                  count_nx = count_ff - 1'b1;
               end else begin
                  rsp_stat_in = ST_EMPTY;
               end
            end
            default: begin
               rsp_stat_in = ST_OK;
            end
         endcase
         count_in   = count_nx;
         rsp_occ_in = OCC_W'(count_nx);
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pend_ff    <= 1'b0;
         found_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         pend_ff    <= pend_in;
         found_ff   <= found_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      prio_ff     <= prio_in;
      rd_idx_ff   <= rd_idx_in;
      rd_left_ff  <= rd_left_in;
      pend_idx_ff <= pend_idx_in;
      hit_id_ff   <= hit_id_in;
      hit_prio_ff <= hit_prio_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_prio_ff <= rsp_prio_in;
      rsp_occ_ff  <= rsp_occ_in;
   end

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_status = rsp_stat_ff;
   assign rsp_id     = rsp_id_ff;
   assign rsp_prio   = rsp_prio_ff;
   assign rsp_occ    = rsp_occ_ff;

endmodule

`default_nettype wire

/* design/sorted_priority_process_queue.sv */
// one ram read per held entry walked between the accepted word and its result
//   (insert walks from the tail until it meets a smaller or equal priority, and walks
//   nothing when the queue is full; delete and dequeue walk every held entry)
// one word at a time: the next word is taken only once the current one is finished;
//   a finished result waits in the output register while the next word is taken
// reset: synchronous, clears the held count, so the queue starts empty
`default_nettype none

module sorted_priority_process_queue #(
   parameter int QUEUE_DEPTH = sppq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [sppq_pkg::REQ_DATA_W-1:0]   req_tdata,  // proc_id, prio
   input  wire logic [sppq_pkg::OP_W-1:0]         req_tuser,  // opcode
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sppq_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // out_id, out_prio, occupancy
   output logic [sppq_pkg::STAT_W-1:0]            rsp_tuser   // status
);

   import sppq_pkg::*;

   cmd_type            cmd;
   sts_type            sts;
   logic [ID_W-1:0]    rsp_id;
   logic [PRIO_W-1:0]  rsp_prio;
   logic [OCC_W-1:0]   rsp_occ;

   sppq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sppq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_op     (req_tuser),
      .req_id     (req_tdata[ID_W-1:0]),
      .req_prio   (req_tdata[ID_W+PRIO_W-1:ID_W]),
      .rsp_valid  (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_id     (rsp_id),
      .rsp_prio   (rsp_prio),
      .rsp_occ    (rsp_occ)
   );

   assign rsp_tdata = {{(RSP_DATA_W-ID_W-PRIO_W-OCC_W){1'b0}}, rsp_occ, rsp_prio, rsp_id};

endmodule

`default_nettype wire

/* design/sppq_checker.sv */
// port level checks for the sorted priority process queue, bound to the top level
// depends on sppq_pkg and sorted_priority_process_queue
`default_nettype none

module sppq_checker #(
   parameter int QUEUE_DEPTH = sppq_pkg::QUEUE_DEPTH_DEF
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [sppq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic [sppq_pkg::STAT_W-1:0]       rsp_tuser
);

   import sppq_pkg::*;

   logic [ID_W-1:0]   out_id;
   logic [PRIO_W-1:0] out_prio;
   logic [OCC_W-1:0]  occ;

   assign out_id   = rsp_tdata[ID_W-1:0];
   assign out_prio = rsp_tdata[ID_W+PRIO_W-1:ID_W];
   assign occ      = rsp_tdata[ID_W+PRIO_W+OCC_W-1:ID_W+PRIO_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while one is in work");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (QUEUE_DEPTH > 31) || (int'(occ) <= QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL) |-> occ == OCC_W'(QUEUE_DEPTH))
      else $error("full status with queue not full");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == ST_NOT_FOUND) || (rsp_tuser == ST_EMPTY))
      |-> (out_id == '0) && (out_prio == '0) && ((rsp_tuser != ST_EMPTY) || (occ == '0)))
      else $error("miss result carries an entry");

endmodule

bind sorted_priority_process_queue sppq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sppq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
